@@ hdl/gnb_pkg.sv @@
// Package for the Gaussian naive Bayes classifier.
// Holds the payload and control structs, codes, and the log lookup.
// No dependencies.
package gnb_pkg;

    localparam int LN2_Q16 = 45426;
    localparam int DIV_NW  = 48;
    localparam int DIV_DW  = 40;

    localparam logic [1:0] CFG_FEATURE_COUNT  = 2'd0;
    localparam logic [1:0] CFG_VARIANCE_FLOOR = 2'd1;

    localparam logic [1:0] CMD_TRAIN    = 2'd0;
    localparam logic [1:0] CMD_CLASSIFY = 2'd1;
    localparam logic [1:0] CMD_CLEAR    = 2'd2;

    typedef struct packed {
        logic              operation;
        logic [2:0]        class_label;
        logic signed [15:0] feature_value;
        logic              last_feature;
    } t_in;

    typedef struct packed {
        logic [2:0]         best_class;
        logic               no_model;
        logic signed [31:0] best_score;
    } t_out;

    typedef struct packed {
        logic [1:0]         code;
        logic [2:0]         label;
        logic signed [15:0] x;
        logic [7:0]         addr;
        logic               use_f;
        logic               last;
    } t_cmd;

    typedef struct packed {
        logic               vld;
        logic               found;
        logic [5:0]         cls;
        logic signed [31:0] score;
    } t_best;

    function automatic logic [15:0] f_ln_frac(input logic [3:0] idx);
        logic [15:0] r;
        begin
            case (idx)
                4'd0:    r = 16'd0;
                4'd1:    r = 16'd3973;
                4'd2:    r = 16'd7719;
                4'd3:    r = 16'd11262;
                4'd4:    r = 16'd14624;
                4'd5:    r = 16'd17821;
                4'd6:    r = 16'd20870;
                4'd7:    r = 16'd23783;
                4'd8:    r = 16'd26573;
                4'd9:    r = 16'd29248;
                4'd10:   r = 16'd31818;
                4'd11:   r = 16'd34292;
                4'd12:   r = 16'd36675;
                4'd13:   r = 16'd38975;
                4'd14:   r = 16'd41197;
                default: r = 16'd43345;
            endcase
            return r;
        end
    endfunction

    // ln(v) in Q16.16 for a count, v = 0 treated as 1
    function automatic logic signed [31:0] f_ln_int(input logic [18:0] v);
        logic [4:0]  k;
        logic [18:0] sh;
        begin
            k = 5'd0;
            for (int i = 0; i < 19; i++) begin
                if (v[i]) k = 5'(i);
            end
            sh = v << (5'd18 - k);
            return $signed(32'(k) * 32'(LN2_Q16)) + $signed({16'b0, f_ln_frac(sh[17:14])});
        end
    endfunction

endpackage

@@ hdl/gnb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gnb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/gnb_div.sv @@
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on gnb_pkg for operand widths.
module gnb_div import gnb_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_num,
    input  logic [DIV_DW-1:0] i_den,
    output logic              o_busy,
    output logic              o_done,
    output logic [DIV_NW-1:0] o_quo,
    output logic              o_rem_nz
);
    localparam int CW = $clog2(DIV_NW + 1);

    logic [DIV_NW-1:0] r_quo, n_quo;
    logic [DIV_DW-1:0] r_rem, n_rem;
    logic [DIV_DW-1:0] r_den;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_busy, n_busy, r_done, n_done;
    logic [DIV_DW:0]   rem_sh;
    logic [DIV_DW:0]   diff;

    always_comb begin
        rem_sh = {r_rem, r_quo[DIV_NW-1]};
        diff   = rem_sh - {1'b0, r_den};
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_quo  = i_num;
            n_rem  = '0;
            n_cnt  = CW'(DIV_NW);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!diff[DIV_DW]) begin
                n_rem = diff[DIV_DW-1:0];
                n_quo = {r_quo[DIV_NW-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[DIV_DW-1:0];
                n_quo = {r_quo[DIV_NW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_busy   = r_busy;
    assign o_done   = r_done;
    assign o_quo    = r_quo;
    assign o_rem_nz = |r_rem;
endmodule

@@ hdl/gnb_cell.sv @@
// One class of the classifier: its count, sums, running score and argmax stage.
// Depends on gnb_pkg, gnb_ram and gnb_div.
module gnb_cell import gnb_pkg::*; #(
    parameter int IDX          = 0,
    parameter int MAX_FEATURES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_go,
    input  t_cmd               i_cmd,
    input  logic [15:0]        i_vfloor,
    input  logic signed [31:0] i_ln_total,
    input  t_best              i_tok,
    output t_best              o_tok,
    output logic               o_busy,
    output logic               o_full
);
    localparam int AW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;

    localparam logic [3:0] C_IDLE = 4'd0;
    localparam logic [3:0] C_TRD  = 4'd1;
    localparam logic [3:0] C_CRD  = 4'd2;
    localparam logic [3:0] C_MEAN = 4'd3;
    localparam logic [3:0] C_SQ   = 4'd4;
    localparam logic [3:0] C_VAR  = 4'd5;
    localparam logic [3:0] C_NORM = 4'd6;
    localparam logic [3:0] C_TERM = 4'd7;
    localparam logic [3:0] C_ACC  = 4'd8;

    logic [3:0]               r_st, n_st;
    logic [15:0]              r_cnt;
    logic signed [31:0]       r_score;
    logic [MAX_FEATURES-1:0]  r_vld;
    logic [47:0]              r_sq;
    logic                     r_neg;
    logic signed [15:0]       r_mean;
    logic [31:0]              r_msq;
    logic [33:0]              r_dsq;
    logic [39:0]              r_var, r_nv;
    logic [5:0]               r_k;
    logic signed [31:0]       r_con;
    t_best                    r_tok, n_tok;

    logic [AW-1:0]      addr;
    logic [39:0]        sum_q, sum_rd;
    logic [47:0]        sq_q, sq_rd;
    logic               ram_we;
    logic [39:0]        sum_wr;
    logic [47:0]        sq_wr;
    logic               gate;

    logic               dv_start, dv_busy, dv_done, dv_rnz;
    logic [DIV_NW-1:0]  dv_num, dv_quo;
    logic [DIV_DW-1:0]  dv_den;

    logic signed [40:0] s_new;
    logic signed [31:0] xx;
    logic [48:0]        q_new;
    logic [39:0]        mag;
    logic [40:0]        mq;
    logic signed [41:0] ms;
    logic signed [15:0] mean_c;
    logic signed [31:0] msq_p;
    logic signed [16:0] diff;
    logic signed [33:0] dsq_p;
    logic signed [48:0] v49;
    logic [39:0]        vv, flo, var_c;
    logic signed [31:0] km8, lnv, half;
    logic signed [49:0] con50;
    logic signed [31:0] con_c;
    logic signed [32:0] acc33;
    logic signed [31:0] acc_c;
    logic signed [31:0] ln_n, pr, sc;
    logic signed [32:0] sc33;

    assign addr   = i_cmd.addr[AW-1:0];
    assign sum_rd = r_vld[addr] ? sum_q : 40'd0;
    assign sq_rd  = r_vld[addr] ? sq_q : 48'd0;
    assign gate   = (32'(i_cmd.label) == IDX) && (r_cnt != 16'hFFFF);

    gnb_ram #(.WIDTH(40), .DEPTH(MAX_FEATURES)) u_sum (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(addr), .i_wdata(sum_wr),
        .i_raddr(addr), .o_rdata(sum_q)
    );

    gnb_ram #(.WIDTH(48), .DEPTH(MAX_FEATURES)) u_sq (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(addr), .i_wdata(sq_wr),
        .i_raddr(addr), .o_rdata(sq_q)
    );

    gnb_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(dv_start), .i_num(dv_num),
        .i_den(dv_den), .o_busy(dv_busy), .o_done(dv_done), .o_quo(dv_quo),
        .o_rem_nz(dv_rnz)
    );

    // training update
    always_comb begin
        xx     = i_cmd.x * i_cmd.x;
        s_new  = $signed({sum_rd[39], sum_rd}) + 41'(i_cmd.x);
        q_new  = {1'b0, sq_rd} + {17'b0, xx};
        if (s_new[40] != s_new[39]) begin
            sum_wr = s_new[40] ? {1'b1, 39'b0} : {1'b0, {39{1'b1}}};
        end else begin
            sum_wr = s_new[39:0];
        end
        sq_wr  = q_new[48] ? {48{1'b1}} : q_new[47:0];
        ram_we = (r_st == C_TRD);
    end

    // classification datapath
    always_comb begin
        mag    = sum_rd[39] ? 40'(-$signed(sum_rd)) : sum_rd;
        mq     = dv_quo[40:0] + 41'(r_neg & dv_rnz);
        ms     = r_neg ? -$signed({1'b0, mq}) : $signed({1'b0, mq});
        if (ms > 42'sd32767) begin
            mean_c = 16'sh7FFF;
        end else if (ms < -42'sd32768) begin
            mean_c = -16'sh8000;
        end else begin
            mean_c = ms[15:0];
        end
        msq_p  = r_mean * r_mean;
        diff   = 17'(i_cmd.x) - 17'(r_mean);
        dsq_p  = diff * diff;
        v49    = $signed({1'b0, dv_quo}) - $signed({17'b0, r_msq});
        vv     = v49[48] ? 40'd0 : v49[47:8];
        flo    = (i_vfloor == 16'd0) ? 40'd1 : {24'b0, i_vfloor};
        var_c  = (vv < flo) ? flo : vv;
        km8    = $signed(32'(r_k)) - 32'sd8;
        lnv    = km8 * 32'sd45426 + $signed({16'b0, f_ln_frac(r_nv[38:35])});
        half   = lnv[31] ? -((-lnv) >>> 1) : (lnv >>> 1);
        con50  = -50'(half) - $signed({2'b0, dv_quo});
        if (con50 > 50'sh7FFFFFFF) begin
            con_c = 32'sh7FFFFFFF;
        end else if (con50 < -50'sh80000000) begin
            con_c = -32'sh80000000;
        end else begin
            con_c = con50[31:0];
        end
        acc33  = 33'(r_score) + 33'(r_con);
        acc_c  = (acc33[32] != acc33[31]) ?
                 (acc33[32] ? -32'sh80000000 : 32'sh7FFFFFFF) : acc33[31:0];
    end

    always_comb begin
        dv_start = 1'b0;
        dv_num   = {8'b0, mag};
        dv_den   = {24'b0, r_cnt};
        unique case (r_st)
            C_CRD: begin
                dv_start = 1'b1;
            end
            C_MEAN: begin
                dv_start = dv_done;
                dv_num   = r_sq;
            end
            C_VAR: begin
                dv_start = 1'b1;
                dv_num   = {7'b0, r_dsq, 7'b0};
                dv_den   = r_var;
            end
            default: begin
                dv_start = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            C_IDLE: begin
                if (i_go && i_cmd.use_f) begin
                    if (i_cmd.code == CMD_TRAIN && gate) begin
                        n_st = C_TRD;
                    end else if (i_cmd.code == CMD_CLASSIFY && r_cnt != 16'd0) begin
                        n_st = C_CRD;
                    end
                end
            end
            C_TRD:  n_st = C_IDLE;
            C_CRD:  n_st = C_MEAN;
            C_MEAN: if (dv_done) n_st = C_SQ;
            C_SQ:   if (dv_done) n_st = C_VAR;
            C_VAR:  n_st = C_NORM;
            C_NORM: if (r_nv[39]) n_st = C_TERM;
            C_TERM: if (!dv_busy) n_st = C_ACC;
            C_ACC:  n_st = C_IDLE;
            default: n_st = C_IDLE;
        endcase
    end

    // argmax stage
    always_comb begin
        ln_n  = f_ln_int({3'b0, r_cnt});
        pr    = ln_n - i_ln_total;
        sc33  = 33'(r_score) + 33'(pr);
        sc    = (sc33[32] != sc33[31]) ?
                (sc33[32] ? -32'sh80000000 : 32'sh7FFFFFFF) : sc33[31:0];
        n_tok = i_tok;
        if (i_tok.vld && r_cnt != 16'd0 && (!i_tok.found || sc > i_tok.score)) begin
            n_tok.found = 1'b1;
            n_tok.cls   = 6'(IDX);
            n_tok.score = sc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= C_IDLE;
            r_cnt   <= '0;
            r_score <= '0;
            r_vld   <= '0;
            r_tok   <= '0;
        end else begin
            r_st  <= n_st;
            r_tok <= n_tok;
            if (i_go && r_st == C_IDLE) begin
                if (i_cmd.code == CMD_TRAIN && gate && i_cmd.last) begin
                    r_cnt <= r_cnt + 1'b1;
                end
                if (i_cmd.code == CMD_CLEAR) begin
                    r_score <= '0;
                end
            end
            if (r_st == C_TRD) begin
                r_vld[addr] <= 1'b1;
            end
            if (r_st == C_ACC) begin
                r_score <= acc_c;
            end
        end
        if (r_st == C_CRD) begin
            r_sq  <= sq_rd;
            r_neg <= sum_rd[39];
        end
        if (r_st == C_MEAN && dv_done) begin
            r_mean <= mean_c;
        end
        if (r_st == C_SQ) begin
            r_msq <= msq_p;
            r_dsq <= dsq_p;
        end
        if (r_st == C_SQ && dv_done) begin
            r_var <= var_c;
        end
        if (r_st == C_VAR) begin
            r_nv <= r_var;
            r_k  <= 6'd39;
        end else if (r_st == C_NORM && !r_nv[39]) begin
            r_nv <= {r_nv[38:0], 1'b0};
            r_k  <= r_k - 1'b1;
        end
        if (r_st == C_TERM) begin
            r_con <= con_c;
        end
    end

    assign o_tok  = r_tok;
    assign o_busy = (r_st != C_IDLE);
    assign o_full = (r_cnt == 16'hFFFF);
endmodule

@@ hdl/gaussian_naive_bayes_classifier.sv @@
// Top level of the Gaussian naive Bayes classifier.
// Depends on gnb_pkg and gnb_cell.
//
// Input channel (i_in_valid / o_in_ready, i_in_data) takes one feature per
// transaction; last_feature closes a row. Output channel (o_out_valid /
// i_out_ready, o_out_data) gives one result per classify row.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 feature_count, 1 variance_floor).
// One item is worked on at a time; o_in_ready is high only when idle.
// Training item: sum RAM read, then update and write.
// Classify item: the per-class bit-serial divider runs three 48-step
// divisions (mean, mean square, distance term); all classes run in
// parallel.
// A classify row end adds a pass of the argmax token down the class
// chain; every row end adds a clear step.
// The result sits in an output register; the next item is accepted while it
// waits. A second result waits inside until the register is free.
// Reset clears counts, sums (per-entry valid bits), scores and position.
module gaussian_naive_bayes_classifier import gnb_pkg::*; #(
    parameter int CLASSES      = 8,
    parameter int MAX_FEATURES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    localparam int PW = $clog2(MAX_FEATURES + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_W0    = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_CHAIN = 3'd3;
    localparam logic [2:0] ST_HOLD  = 3'd4;
    localparam logic [2:0] ST_CLEAR = 3'd5;

    logic [2:0]    r_st, n_st;
    logic [4:0]    r_fc;
    logic [15:0]   r_vf;
    logic [18:0]   r_total;
    logic [PW-1:0] r_pos;
    t_cmd          r_cmd;
    logic          r_go;
    logic          r_start;
    t_best         r_res;
    t_out          r_out;
    logic          r_ovld;

    t_best              tok [CLASSES+1];
    logic [CLASSES-1:0] busy, full;
    logic signed [31:0] ln_total;
    logic               acc, use_c, gate, out_free;

    assign ln_total = f_ln_int(r_total);
    assign acc      = i_in_valid && o_in_ready;
    assign use_c    = (32'(r_pos) < 32'(r_fc)) && (32'(r_pos) < MAX_FEATURES);
    assign out_free = !r_ovld || i_out_ready;

    always_comb begin
        gate = 1'b0;
        for (int c = 0; c < CLASSES; c++) begin
            if (32'(i_in_data.class_label) == c && !full[c]) gate = 1'b1;
        end
    end

    always_comb begin
        tok[0]       = '0;
        tok[0].vld   = r_start;
    end

    genvar g;
    generate
        for (g = 0; g < CLASSES; g++) begin : g_cell
            gnb_cell #(.IDX(g), .MAX_FEATURES(MAX_FEATURES)) u_cell (
                .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(r_go), .i_cmd(r_cmd),
                .i_vfloor(r_vf), .i_ln_total(ln_total), .i_tok(tok[g]),
                .o_tok(tok[g+1]), .o_busy(busy[g]), .o_full(full[g])
            );
        end
    endgenerate

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_IDLE:  if (acc) n_st = ST_W0;
            ST_W0:    n_st = ST_WAIT;
            ST_WAIT: begin
                if (busy == '0) begin
                    if (r_cmd.last && r_cmd.code == CMD_CLASSIFY) begin
                        n_st = ST_CHAIN;
                    end else if (r_cmd.last) begin
                        n_st = ST_CLEAR;
                    end else begin
                        n_st = ST_IDLE;
                    end
                end
            end
            ST_CHAIN: if (tok[CLASSES].vld) n_st = ST_HOLD;
            ST_HOLD:  if (out_free) n_st = ST_CLEAR;
            ST_CLEAR: n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= ST_IDLE;
            r_fc    <= 5'd16;
            r_vf    <= 16'd16;
            r_total <= '0;
            r_pos   <= '0;
            r_go    <= 1'b0;
            r_start <= 1'b0;
            r_ovld  <= 1'b0;
            r_cmd   <= '0;
        end else begin
            r_st    <= n_st;
            r_go    <= acc || (r_st == ST_CLEAR);
            r_start <= (r_st == ST_WAIT) && (busy == '0) && r_cmd.last &&
                       (r_cmd.code == CMD_CLASSIFY);
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_FEATURE_COUNT:  r_fc <= i_cfg_data[4:0];
                    CFG_VARIANCE_FLOOR: r_vf <= i_cfg_data;
                    default: ;
                endcase
            end
            if (acc) begin
                r_cmd.code  <= i_in_data.operation ? CMD_CLASSIFY : CMD_TRAIN;
                r_cmd.label <= i_in_data.class_label;
                r_cmd.x     <= i_in_data.feature_value;
                r_cmd.addr  <= 8'(r_pos);
                r_cmd.use_f <= use_c;
                r_cmd.last  <= i_in_data.last_feature;
                if (!i_in_data.operation && i_in_data.last_feature && gate &&
                    r_total != 19'h7FFFF) begin
                    r_total <= r_total + 1'b1;
                end
            end
            if (r_st == ST_WAIT && busy == '0 && !r_cmd.last &&
                32'(r_pos) < MAX_FEATURES) begin
                r_pos <= r_pos + 1'b1;
            end
            if (r_st == ST_CLEAR) begin
                r_cmd.code <= CMD_CLEAR;
                r_pos      <= '0;
            end
            if (r_st == ST_HOLD && out_free) begin
                r_ovld <= 1'b1;
            end else if (r_ovld && i_out_ready) begin
                r_ovld <= 1'b0;
            end
        end
        if (r_st == ST_CHAIN && tok[CLASSES].vld) begin
            r_res <= tok[CLASSES];
        end
        if (r_st == ST_HOLD && out_free) begin
            r_out.best_class <= r_res.found ? 3'(r_res.cls) : 3'd0;
            r_out.no_model   <= !r_res.found;
            r_out.best_score <= r_res.found ? r_res.score : 32'sd0;
        end
    end

    assign o_in_ready  = (r_st == ST_IDLE);
    assign o_out_valid = r_ovld;
    assign o_out_data  = r_out;
endmodule

@@ hdl/gnb_checker.sv @@
// Port-level checks for the Gaussian naive Bayes classifier, bound to the top.
// Depends on gnb_pkg and gaussian_naive_bayes_classifier.
module gnb_port_checks import gnb_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out_data
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second transaction taken while busy");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result present after reset");

    a_no_model: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.no_model |->
        o_out_data.best_score == 32'sd0 && o_out_data.best_class == 3'd0)
        else $error("no-model result carries a class or score");
endmodule

bind gaussian_naive_bayes_classifier gnb_port_checks u_gnb_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
    .o_in_ready(o_in_ready), .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready), .o_out_data(o_out_data)
);

@@ sim/gnb_checker.sv @@
// Checker for the Gaussian naive Bayes classifier: watches the feature, result and
// register-write ports, keeps its own copy of the model state, predicts every result
// and compares it field by field. Depends on gnb_pkg.
module gnb_checker import gnb_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  t_in         in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  t_out        out_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_idx,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCLS = 8;
    localparam int NFEAT = 16;
    localparam longint SUM_HI = 64'sd549755813887;
    localparam longint SUM_LO = -SUM_HI - 1;
    localparam longint unsigned SQ_MAX = 64'd281474976710655;
    localparam int LN_TAB [16] = '{0, 3973, 7719, 11262, 14624, 17821, 20870, 23783,
                                   26573, 29248, 31818, 34292, 36675, 38975, 41197, 43345};

    int unsigned       cls_cnt [NCLS];
    int unsigned       row_total;
    longint            sum_x [NCLS*NFEAT];
    longint unsigned   sum_xx [NCLS*NFEAT];
    int                score_acc [NCLS];
    int unsigned       pos;
    int unsigned       cfg_fc;
    int unsigned       cfg_vf;
    t_out              result_q [$];

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint ln_fixed(longint unsigned v, int frac);
        int k;
        int idx;
        if (v == 0) v = 1;
        k = 63;
        while (v[k] == 1'b0) k--;
        if (k >= 4) idx = int'((v >> (k - 4)) & 15);
        else idx = int'((v << (4 - k)) & 15);
        return longint'(k - frac) * 45426 + LN_TAB[idx];
    endfunction

    function automatic longint log_likelihood(int c, int p, longint x);
        int i;
        longint n, s, mean, var16, diff;
        longint unsigned vq, flo, term, dd;
        i = c * NFEAT + p;
        n = longint'(cls_cnt[c]);
        s = sum_x[i];
        mean = (s >= 0) ? s / n : -((-s + n - 1) / n);
        if (mean > 32767) mean = 32767;
        if (mean < -32768) mean = -32768;
        var16 = longint'(sum_xx[i] / longint'(n)) - mean * mean;
        if (var16 < 0) var16 = 0;
        vq = longint'(var16) >> 8;
        flo = (cfg_vf != 0) ? cfg_vf : 1;
        if (vq < flo) vq = flo;
        diff = x - mean;
        dd = diff * diff;
        term = dd * 128 / vq;
        return clamp32(-(ln_fixed(vq, 8) / 2) - longint'(term));
    endfunction

    task automatic predict_item(t_in d);
        int unsigned eff, lbl;
        longint x, s;
        longint unsigned q;
        int i;
        bit found;
        int best, best_sc, sc;
        t_out r;
        eff = (cfg_fc < NFEAT) ? cfg_fc : NFEAT;
        x = longint'(d.feature_value);
        lbl = d.class_label;
        if (d.operation == 1'b0) begin
            if (cls_cnt[lbl] < 65535) begin
                if (pos < eff) begin
                    i = lbl * NFEAT + pos;
                    s = sum_x[i] + x;
                    q = sum_xx[i] + longint'(x * x);
                    sum_x[i] = (s > SUM_HI) ? SUM_HI : ((s < SUM_LO) ? SUM_LO : s);
                    sum_xx[i] = (q > SQ_MAX) ? SQ_MAX : q;
                end
                if (d.last_feature) begin
                    cls_cnt[lbl]++;
                    if (row_total < 524287) row_total++;
                end
            end
        end else begin
            if (pos < eff) begin
                for (int c = 0; c < NCLS; c++) begin
                    if (cls_cnt[c] != 0)
                        score_acc[c] = int'(clamp32(longint'(score_acc[c])
                                       + log_likelihood(c, pos, x)));
                end
            end
            if (d.last_feature) begin
                found = 0;
                best = 0;
                best_sc = 0;
                for (int c = 0; c < NCLS; c++) begin
                    if (cls_cnt[c] != 0) begin
                        sc = int'(clamp32(longint'(score_acc[c]) + ln_fixed(cls_cnt[c], 0)
                                          - ln_fixed(row_total, 0)));
                        if (!found || sc > best_sc) begin
                            found = 1;
                            best = c;
                            best_sc = sc;
                        end
                    end
                end
                r.best_class = best[2:0];
                r.no_model = !found;
                r.best_score = best_sc;
                result_q.push_back(r);
            end
        end
        if (d.last_feature) begin
            foreach (score_acc[c]) score_acc[c] = 0;
            pos = 0;
        end else if (pos < NFEAT) begin
            pos++;
        end
    endtask

    always @(posedge clk) begin
        t_out e;
        if (!rst_n) begin
            foreach (cls_cnt[c]) cls_cnt[c] = 0;
            foreach (score_acc[c]) score_acc[c] = 0;
            foreach (sum_x[i]) begin
                sum_x[i] = 0;
                sum_xx[i] = 0;
            end
            row_total = 0;
            pos = 0;
            cfg_fc = 16;
            cfg_vf = 16;
            result_q.delete();
        end else begin
            if (cfg_we) begin
                if (cfg_idx == CFG_FEATURE_COUNT) cfg_fc = cfg_data & 31;
                else if (cfg_idx == CFG_VARIANCE_FLOOR) cfg_vf = cfg_data;
            end
            if (out_valid && out_ready) begin
                if (result_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result %p", $time, out_data);
                end else begin
                    e = result_q.pop_front();
                    if (e.best_class !== out_data.best_class) begin
                        fail_count++;
                        $display("%0t: best_class expected %0d actual %0d", $time,
                                 e.best_class, out_data.best_class);
                    end
                    if (e.no_model !== out_data.no_model) begin
                        fail_count++;
                        $display("%0t: no_model expected %0d actual %0d", $time,
                                 e.no_model, out_data.no_model);
                    end
                    if (e.best_score !== out_data.best_score) begin
                        fail_count++;
                        $display("%0t: best_score expected %0d actual %0d", $time,
                                 e.best_score, out_data.best_score);
                    end
                end
            end
            if (in_valid && in_ready) predict_item(in_data);
        end
        pending = result_q.size();
    end

    initial begin
        fail_count = 0;
        pending = 0;
    end
endmodule

@@ sim/tb_gaussian_naive_bayes_classifier.sv @@
// Top of the classifier testbench: clock, reset, directed and random feature rows,
// register writes between phases, output backpressure and the verdict.
// Depends on gnb_pkg, gnb_checker and gaussian_naive_bayes_classifier.
module tb_gaussian_naive_bayes_classifier import gnb_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 400;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out_data;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    int          fail_count;
    int          pending;
    int          cycles;
    int          sender_idle_pct;
    int          stall_pct;
    int          hold_cycles;
    int          sent;
    int unsigned row_len;

    gaussian_naive_bayes_classifier dut (.*);

    gnb_checker u_checker (
        .clk(i_clk), .rst_n(i_rst_n),
        .in_valid(i_in_valid), .in_ready(o_in_ready), .in_data(i_in_data),
        .out_valid(o_out_valid), .out_ready(i_out_ready), .out_data(o_out_data),
        .cfg_we(i_cfg_we), .cfg_idx(i_cfg_idx), .cfg_data(i_cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_out_ready <= 1'b0;
                hold_cycles--;
            end else begin
                i_out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_item(logic op, logic [2:0] lbl, logic signed [15:0] x, logic last);
        bit gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct) begin
            if (!gap) i_in_valid <= 1'b0;
            gap = 1;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= '{operation: op, class_label: lbl, feature_value: x, last_feature: last};
        do @(posedge i_clk); while (!o_in_ready);
        sent++;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [15:0] sample_value(int lbl, int p);
        int v;
        if ($urandom_range(99) < 5) return 16'($urandom);
        v = lbl * 300 - 1000 + p * 40 + int'($urandom_range(200)) - 100;
        return 16'(v);
    endfunction

    task automatic send_row(logic op, int lbl, int len, bit mixed);
        int l;
        for (int p = 0; p < len; p++) begin
            l = (mixed && $urandom_range(3) == 0) ? int'($urandom_range(7)) : lbl;
            send_item(op, 3'(op ? $urandom : l), sample_value(lbl, p), p == len - 1);
        end
    endtask

    initial begin
        int fc_set [4] = '{16, 5, 2, 31};
        int vf_set [4] = '{16, 1, 65535, 0};
        int idle_set [4] = '{0, 88, 0, 12};
        int stall_set [4] = '{0, 0, 88, 12};
        int target, len, lbl;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        cycles = 0;
        sent = 0;
        hold_cycles = 0;
        sender_idle_pct = 0;
        stall_pct = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no class trained yet
        send_item(1'b1, 3'd0, 16'sh0100, 1'b0);
        send_item(1'b1, 3'd7, -16'sd32768, 1'b1);
        write_reg(CFG_FEATURE_COUNT, 16'd2);
        send_item(1'b0, 3'd3, -16'sd32768, 1'b0);
        send_item(1'b0, 3'd3, 16'sd32767, 1'b1);
        // identical class models tie, lowest index wins
        send_item(1'b0, 3'd5, -16'sd32768, 1'b0);
        send_item(1'b0, 3'd5, 16'sd32767, 1'b1);
        send_item(1'b1, 3'd2, 16'sd32767, 1'b0);
        send_item(1'b1, 3'd2, -16'sd32768, 1'b1);
        // mixed labels, last item decides the row's class
        send_item(1'b0, 3'd0, 16'sh0000, 1'b0);
        send_item(1'b0, 3'd7, -16'sh0001, 1'b1);
        // long row past the position limit
        for (int p = 0; p < 18; p++) send_item(1'b1, 3'd1, 16'(p * 64), p == 17);
        write_reg(CFG_FEATURE_COUNT, 16'd0);
        send_item(1'b1, 3'd4, 16'sh7f00, 1'b1);
        write_reg(2'd2, 16'hffff);
        write_reg(2'd3, 16'h0000);
        send_item(1'b1, 3'd4, 16'sh0000, 1'b1);

        for (int ph = 0; ph < 4; ph++) begin
            write_reg(CFG_FEATURE_COUNT, 16'(fc_set[ph]));
            write_reg(CFG_VARIANCE_FLOOR, 16'(vf_set[ph]));
            sender_idle_pct = idle_set[ph];
            stall_pct = stall_set[ph];
            target = sent + 412;
            while (sent < target) begin
                len = (fc_set[ph] < 16) ? fc_set[ph] : 16;
                if ($urandom_range(9) == 0) len = int'($urandom_range(1, 20));
                lbl = int'($urandom_range(7));
                if ($urandom_range(99) < 55) send_row(1'b0, lbl, len, $urandom_range(9) == 0);
                else send_row(1'b1, lbl, len, 1'b0);
                if ($urandom_range(99) < 3) drain();
            end
            if (ph == 1) begin
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
                hold_cycles = 3000;
                for (int k = 0; k < 6; k++) send_item(1'b1, 3'd0, sample_value(k, 0), 1'b1);
                i_in_valid <= 1'b0;
                do @(posedge i_clk); while (pending != 0);
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
hdl/gnb_pkg.sv
hdl/gnb_ram.sv
hdl/gnb_div.sv
hdl/gnb_cell.sv
hdl/gaussian_naive_bayes_classifier.sv
hdl/gnb_checker.sv
sim/gnb_checker.sv
sim/tb_gaussian_naive_bayes_classifier.sv
